// ===== rtl/asro2d_pkg.sv =====
// Shared constants, types and a rounding helper of the 2D scale/rotate/offset transform.
package asro2d_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 16;

   localparam int COORD_W    = 32;
   localparam int SCALE_W    = 24;
   localparam int ANGLE_W    = 16;
   localparam int RECIP_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
   localparam int TMAG_W     = TRIG_FRAC_BITS + 1;
   localparam int FRAC_SHIFT = 32 - ANGLE_BITS;

   localparam int V_W        = 40;
   localparam int PROD_W     = V_W + TMAG_W;
   localparam int TERM_MAG_W = 41;
   localparam int TERM_W     = TERM_MAG_W + 1;
   localparam int SUM_W      = 44;
   localparam int RM_W       = 35;
   localparam int RH_W       = RM_W + 16;
   localparam int RP_W       = RH_W + 1;
   localparam int RES_W      = RP_W + 1;
   localparam int NSTG       = 9;

   localparam int DIV_STEPS  = 34;
   localparam int POLY_LAST  = 11;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0] POLY_A1 = 32'd1686629713;
   localparam logic [31:0] POLY_A3 = 32'd693598668;
   localparam logic [31:0] POLY_A5 = 32'd85569306;
   localparam logic [31:0] POLY_A7 = 32'd5026995;
   localparam logic [31:0] POLY_A9 = 32'd172272;

   localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCALE_X  = 3'd0,
      REG_SCALE_Y  = 3'd1,
      REG_ANGLE    = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_DIV,
      ENG_POLY
   } eng_state_type;

   typedef struct packed {
      logic [SCALE_W-1:0]        scale_x;
      logic [SCALE_W-1:0]        scale_y;
      logic signed [COORD_W-1:0] offset_x;
      logic signed [COORD_W-1:0] offset_y;
      logic signed [TRIG_W-1:0]  cos_value;
      logic signed [TRIG_W-1:0]  sin_value;
      logic [RECIP_W-1:0]        recip_x;
      logic [RECIP_W-1:0]        recip_y;
      logic                      busy;
   } coef_type;

   // round half away from zero of a sign/magnitude rotation product
   function automatic logic signed [TERM_W-1:0] round_term(input logic [PROD_W-1:0] p,
                                                          input logic neg);
      logic [PROD_W:0]       r;
      logic [TERM_MAG_W-1:0] m;
      logic signed [TERM_W-1:0] s;
      r = (PROD_W+1)'(p) + ((PROD_W+1)'(1) << (TRIG_FRAC_BITS - 1));
      m = TERM_MAG_W'(r >> TRIG_FRAC_BITS);
      s = $signed({1'b0, m});
      return neg ? -s : s;
   endfunction

endpackage

// ===== rtl/asro2d_coef.sv =====
// Configuration registers with derived sine/cosine and reciprocal scales.
module asro2d_coef import asro2d_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output coef_type              coef
);

   logic [SCALE_W-1:0]        scale_x_ff, scale_y_ff;
   logic [ANGLE_W-1:0]        angle_ff;
   logic signed [COORD_W-1:0] offset_x_ff, offset_y_ff;
   logic signed [TRIG_W-1:0]  cos_ff, sin_ff;
   logic [RECIP_W-1:0]        recip_x_ff, recip_y_ff;
   logic                      pend_trig_ff, pend_trig_in;
   logic                      pend_rx_ff, pend_rx_in;
   logic                      pend_ry_ff, pend_ry_in;
   eng_state_type             state_ff, state_in;

   logic [5:0]          div_cnt_ff;
   logic [33:0]         num_ff;
   logic [SCALE_W-1:0]  rem_ff, dvs_ff;
   logic                div_y_ff;
   logic [3:0]          step_ff;
   logic                second_ff;
   logic [1:0]          quad_ff;
   logic [30:0]         u_ff, u2_ff;
   logic [31:0]         t_ff;
   logic [62:0]         prod_ff;
   logic [TMAG_W-1:0]   sf_ff;

   csr_idx_type         idx;
   logic                hit_sx, hit_sy, hit_ang;
   logic [SCALE_W-1:0]  wr_scale;
   logic                start_trig, start_rx, start_ry;
   logic                div_last, poly_last;
   logic [SCALE_W:0]    rem2, rem_sub;
   logic                ge;
   logic [33:0]         num_nx;
   logic [RECIP_W-1:0]  div_res;
   logic [SCALE_W-1:0]  div_src;
   logic [ANGLE_BITS-1:0] ang;
   logic [30:0]         mul_a;
   logic [31:0]         mul_b;
   logic [62:0]         prod;
   logic [31:0]         poly_add [6];
   logic [31:0]         t_sub;
   logic [32:0]         tq;
   logic [30:0]         tclamp;
   logic [31:0]         rsum;
   logic [TMAG_W-1:0]   rnd;
   logic signed [TRIG_W-1:0] sf_s, cf_s;

   assign idx      = csr_idx_type'(csr_index);
   assign hit_sx   = csr_write_enable && (idx == REG_SCALE_X);
   assign hit_sy   = csr_write_enable && (idx == REG_SCALE_Y);
   assign hit_ang  = csr_write_enable && (idx == REG_ANGLE);
   assign wr_scale = (csr_write_data[SCALE_W-1:0] == '0) ? SCALE_W'(1)
                                                         : csr_write_data[SCALE_W-1:0];

   always_comb begin
      state_in   = state_ff;
      start_trig = 1'b0;
      start_rx   = 1'b0;
      start_ry   = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            priority if (pend_trig_ff) begin
               start_trig = 1'b1;
               state_in   = ENG_POLY;
            end else if (pend_rx_ff) begin
               start_rx = 1'b1;
               state_in = ENG_DIV;
            end else if (pend_ry_ff) begin
               start_ry = 1'b1;
               state_in = ENG_DIV;
            end else begin
               state_in = ENG_IDLE;
            end
         end
         ENG_DIV: begin
            if (div_last) state_in = ENG_IDLE;
         end
         ENG_POLY: begin
            if (poly_last && second_ff) state_in = ENG_IDLE;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   assign pend_trig_in = hit_ang | (pend_trig_ff & ~start_trig);
   assign pend_rx_in   = hit_sx | (pend_rx_ff & ~start_rx);
   assign pend_ry_in   = hit_sy | (pend_ry_ff & ~start_ry);

   // restoring divider, one quotient bit per cycle
   assign div_last = (state_ff == ENG_DIV) && (div_cnt_ff == 6'(DIV_STEPS - 1));
   assign rem2     = {rem_ff, num_ff[33]};
   assign ge       = rem2 >= {1'b0, dvs_ff};
   assign rem_sub  = rem2 - {1'b0, dvs_ff};
   assign num_nx   = {num_ff[32:0], ge};
   assign div_res  = (num_nx[33:32] != 2'b00) ? '1 : num_nx[31:0];
   assign div_src  = start_ry ? scale_y_ff : scale_x_ff;

   // sine polynomial on one shared multiplier
   assign ang       = ANGLE_BITS'(angle_ff);
   assign poly_last = (state_ff == ENG_POLY) && (step_ff == 4'(POLY_LAST));
   assign mul_a     = (step_ff == 4'd0 || step_ff == 4'(POLY_LAST - 1)) ? u_ff : u2_ff;
   assign mul_b     = (step_ff == 4'd0) ? {1'b0, u_ff} : t_ff;
   assign prod      = mul_a * mul_b;
   assign poly_add  = '{POLY_A9, POLY_A7, POLY_A5, POLY_A3, POLY_A1, 32'd0};
   assign t_sub     = poly_add[step_ff[3:1]] - ((step_ff == 4'd1) ? 32'd0 : prod_ff[61:30]);
   assign tq        = prod_ff[62:30];
   assign tclamp    = (tq > {2'b00, Q30_ONE}) ? Q30_ONE : tq[30:0];
   assign rsum      = {1'b0, tclamp} + (32'd1 << (29 - TRIG_FRAC_BITS));
   assign rnd       = TMAG_W'(rsum >> (30 - TRIG_FRAC_BITS));
   assign sf_s      = $signed({1'b0, sf_ff});
   assign cf_s      = $signed({1'b0, rnd});

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff   <= SCALE_W'(32'h1_0000);
         scale_y_ff   <= SCALE_W'(32'h1_0000);
         angle_ff     <= '0;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         cos_ff       <= TRIG_ONE;
         sin_ff       <= '0;
         recip_x_ff   <= RECIP_W'(32'h1_0000);
         recip_y_ff   <= RECIP_W'(32'h1_0000);
         pend_trig_ff <= 1'b0;
         pend_rx_ff   <= 1'b0;
         pend_ry_ff   <= 1'b0;
         state_ff     <= ENG_IDLE;
      end else begin
         state_ff     <= state_in;
         pend_trig_ff <= pend_trig_in;
         pend_rx_ff   <= pend_rx_in;
         pend_ry_ff   <= pend_ry_in;
         if (hit_sx) scale_x_ff <= wr_scale;
         if (hit_sy) scale_y_ff <= wr_scale;
         if (hit_ang) angle_ff <= csr_write_data[ANGLE_W-1:0];
         if (csr_write_enable && idx == REG_OFFSET_X) offset_x_ff <= csr_write_data;
         if (csr_write_enable && idx == REG_OFFSET_Y) offset_y_ff <= csr_write_data;
         if (div_last) begin
            if (div_y_ff) recip_y_ff <= div_res;
            else          recip_x_ff <= div_res;
         end
         if (poly_last && second_ff) begin
            unique case (quad_ff)
               2'd0: begin sin_ff <= sf_s;  cos_ff <= cf_s;  end
               2'd1: begin sin_ff <= cf_s;  cos_ff <= -sf_s; end
               2'd2: begin sin_ff <= -sf_s; cos_ff <= -cf_s; end
               default: begin sin_ff <= -cf_s; cos_ff <= sf_s; end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_rx || start_ry) begin
         dvs_ff     <= div_src;
         num_ff     <= 34'h1_0000_0000 + 34'(div_src >> 1);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         div_y_ff   <= start_ry;
      end else if (state_ff == ENG_DIV) begin
         rem_ff     <= ge ? rem_sub[SCALE_W-1:0] : rem2[SCALE_W-1:0];
         num_ff     <= num_nx;
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
      if (start_trig) begin
         u_ff      <= 31'(ang[ANGLE_BITS-3:0]) << FRAC_SHIFT;
         quad_ff   <= ang[ANGLE_BITS-1 -: 2];
         step_ff   <= '0;
         second_ff <= 1'b0;
      end else if (state_ff == ENG_POLY) begin
         if (poly_last) begin
            sf_ff     <= rnd;
            u_ff      <= Q30_ONE - u_ff;
            second_ff <= 1'b1;
            step_ff   <= '0;
         end else if (!step_ff[0]) begin
            prod_ff <= prod;
            step_ff <= step_ff + 4'd1;
         end else begin
            if (step_ff == 4'd1) u2_ff <= prod_ff[60:30];
            t_ff    <= t_sub;
            step_ff <= step_ff + 4'd1;
         end
      end
   end

   assign coef.scale_x   = scale_x_ff;
   assign coef.scale_y   = scale_y_ff;
   assign coef.offset_x  = offset_x_ff;
   assign coef.offset_y  = offset_y_ff;
   assign coef.cos_value = cos_ff;
   assign coef.sin_value = sin_ff;
   assign coef.recip_x   = recip_x_ff;
   assign coef.recip_y   = recip_y_ff;
   assign coef.busy      = (state_ff != ENG_IDLE) | pend_trig_ff | pend_rx_ff | pend_ry_ff;

endmodule

// ===== rtl/affine_scale_rotate_offset_2d.sv =====
// Top level: pipelined 2D scale/rotate/offset point transform and its reverse.
// Takes one point per clock while rsp_ready accepts results and no coefficient update
// is pending, through a nine-stage pipeline (scale multiply, rounding, four rotation
// multiplies, term rounding, sum, magnitude, reciprocal multiply, recombine, saturate).
// A write to a scale register holds off input while the divider forms the reciprocal
// one quotient bit per cycle; an angle write holds it off while the sine polynomial
// runs twice on one shared multiplier. Offset writes take effect at once.
module affine_scale_rotate_offset_2d import asro2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic                      rsp_overflow,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   coef_type coef;

   asro2d_coef u_coef (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .coef             (coef)
   );

   logic [NSTG-1:0] vld_ff, vld_in, rdy;
   logic [NSTG-3:0] fn_ff;

   always_comb begin
      rdy[NSTG-1] = ~vld_ff[NSTG-1] | rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) rdy[k] = ~vld_ff[k] | rdy[k+1];
   end

   assign req_ready = rdy[0] & ~coef.busy;
   assign rsp_valid = vld_ff[NSTG-1];

   always_comb begin
      vld_in[0] = rdy[0] ? (req_valid & req_ready) : vld_ff[0];
      for (int k = 1; k < NSTG; k++) vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) fn_ff[0] <= req_func;
      for (int k = 1; k < NSTG - 2; k++) if (rdy[k]) fn_ff[k] <= fn_ff[k-1];
   end

   // stage 1: scale products or offset removal
   logic [COORD_W-1:0]         mag_px, mag_py;
   logic [55:0]                s1_px_ff, s1_py_ff;
   logic                       s1_nx_ff, s1_ny_ff;
   logic signed [COORD_W:0]    s1_dx_ff, s1_dy_ff;

   assign mag_px = req_point_x[COORD_W-1] ? (~req_point_x + 32'd1) : req_point_x;
   assign mag_py = req_point_y[COORD_W-1] ? (~req_point_y + 32'd1) : req_point_y;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_px_ff <= mag_px * coef.scale_x;
         s1_py_ff <= mag_py * coef.scale_y;
         s1_nx_ff <= req_point_x[COORD_W-1];
         s1_ny_ff <= req_point_y[COORD_W-1];
         s1_dx_ff <= (COORD_W+1)'(req_point_x) - (COORD_W+1)'(coef.offset_x);
         s1_dy_ff <= (COORD_W+1)'(req_point_y) - (COORD_W+1)'(coef.offset_y);
      end
   end

   // stage 2: rotation operands in sign/magnitude
   logic [55:0]      r2x, r2y;
   logic [COORD_W:0] d2x, d2y;
   logic [V_W-1:0]   s2_am_ff, s2_bm_ff;
   logic             s2_an_ff, s2_bn_ff;

   assign r2x = s1_px_ff + 56'h8000;
   assign r2y = s1_py_ff + 56'h8000;
   assign d2x = s1_dx_ff[COORD_W] ? -s1_dx_ff : s1_dx_ff;
   assign d2y = s1_dy_ff[COORD_W] ? -s1_dy_ff : s1_dy_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         if (!fn_ff[0]) begin
            s2_am_ff <= r2x[55:16];
            s2_bm_ff <= r2y[55:16];
            s2_an_ff <= s1_nx_ff;
            s2_bn_ff <= s1_ny_ff;
         end else begin
            s2_am_ff <= V_W'(d2x);
            s2_bm_ff <= V_W'(d2y);
            s2_an_ff <= s1_dx_ff[COORD_W];
            s2_bn_ff <= s1_dy_ff[COORD_W];
         end
      end
   end

   // stage 3: four rotation products
   logic [TRIG_W-1:0] cabs, sabs;
   logic [TMAG_W-1:0] cmag, smag;
   logic              cneg, sneg;
   logic [PROD_W-1:0] s3_ca_ff, s3_sb_ff, s3_sa_ff, s3_cb_ff;
   logic              s3_ca_n_ff, s3_sb_n_ff, s3_sa_n_ff, s3_cb_n_ff;

   assign cneg = coef.cos_value[TRIG_W-1];
   assign sneg = coef.sin_value[TRIG_W-1];
   assign cabs = cneg ? -coef.cos_value : coef.cos_value;
   assign sabs = sneg ? -coef.sin_value : coef.sin_value;
   assign cmag = cabs[TMAG_W-1:0];
   assign smag = sabs[TMAG_W-1:0];

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_ca_ff   <= s2_am_ff * cmag;
         s3_sb_ff   <= s2_bm_ff * smag;
         s3_sa_ff   <= s2_am_ff * smag;
         s3_cb_ff   <= s2_bm_ff * cmag;
         s3_ca_n_ff <= s2_an_ff ^ cneg;
         s3_sb_n_ff <= s2_bn_ff ^ sneg;
         s3_sa_n_ff <= s2_an_ff ^ sneg;
         s3_cb_n_ff <= s2_bn_ff ^ cneg;
      end
   end

   // stage 4: rounded signed terms
   logic signed [TERM_W-1:0] s4_ca_ff, s4_sb_ff, s4_sa_ff, s4_cb_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_ca_ff <= round_term(s3_ca_ff, s3_ca_n_ff);
         s4_sb_ff <= round_term(s3_sb_ff, s3_sb_n_ff);
         s4_sa_ff <= round_term(s3_sa_ff, s3_sa_n_ff);
         s4_cb_ff <= round_term(s3_cb_ff, s3_cb_n_ff);
      end
   end

   // stage 5: rotation sums, forward offset
   logic signed [SUM_W-1:0] ca5, sb5, sa5, cb5;
   logic signed [SUM_W-1:0] s5_x_ff, s5_y_ff;

   assign ca5 = SUM_W'(s4_ca_ff);
   assign sb5 = SUM_W'(s4_sb_ff);
   assign sa5 = SUM_W'(s4_sa_ff);
   assign cb5 = SUM_W'(s4_cb_ff);

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         if (!fn_ff[3]) begin
            s5_x_ff <= ca5 - sb5 + SUM_W'(coef.offset_x);
            s5_y_ff <= sa5 + cb5 + SUM_W'(coef.offset_y);
         end else begin
            s5_x_ff <= ca5 + sb5;
            s5_y_ff <= cb5 - sa5;
         end
      end
   end

   // stage 6: magnitudes for the reciprocal scale
   logic [SUM_W-1:0]        ax6, ay6;
   logic signed [SUM_W-1:0] s6_x_ff, s6_y_ff;
   logic [RM_W-1:0]         s6_xm_ff, s6_ym_ff;

   assign ax6 = s5_x_ff[SUM_W-1] ? -s5_x_ff : s5_x_ff;
   assign ay6 = s5_y_ff[SUM_W-1] ? -s5_y_ff : s5_y_ff;

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s6_x_ff  <= s5_x_ff;
         s6_y_ff  <= s5_y_ff;
         s6_xm_ff <= ax6[RM_W-1:0];
         s6_ym_ff <= ay6[RM_W-1:0];
      end
   end

   // stage 7: reciprocal products, split in halves
   logic signed [SUM_W-1:0] s7_x_ff, s7_y_ff;
   logic [RH_W-1:0]         s7_xh_ff, s7_xl_ff, s7_yh_ff, s7_yl_ff;

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s7_x_ff  <= s6_x_ff;
         s7_y_ff  <= s6_y_ff;
         s7_xh_ff <= s6_xm_ff * coef.recip_x[31:16];
         s7_xl_ff <= s6_xm_ff * coef.recip_x[15:0];
         s7_yh_ff <= s6_ym_ff * coef.recip_y[31:16];
         s7_yl_ff <= s6_ym_ff * coef.recip_y[15:0];
      end
   end

   // stage 8: recombine and select
   logic [RH_W-1:0]         xl8, yl8;
   logic [RP_W-1:0]         px8, py8;
   logic signed [RES_W-1:0] rx8, ry8;
   logic signed [RES_W-1:0] s8_x_ff, s8_y_ff;

   assign xl8 = s7_xl_ff + RH_W'(16'h8000);
   assign yl8 = s7_yl_ff + RH_W'(16'h8000);
   assign px8 = RP_W'(s7_xh_ff) + RP_W'(xl8 >> 16);
   assign py8 = RP_W'(s7_yh_ff) + RP_W'(yl8 >> 16);
   assign rx8 = s7_x_ff[SUM_W-1] ? -$signed({1'b0, px8}) : $signed({1'b0, px8});
   assign ry8 = s7_y_ff[SUM_W-1] ? -$signed({1'b0, py8}) : $signed({1'b0, py8});

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         s8_x_ff <= fn_ff[6] ? rx8 : RES_W'(s7_x_ff);
         s8_y_ff <= fn_ff[6] ? ry8 : RES_W'(s7_y_ff);
      end
   end

   // stage 9: saturation, output register
   localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-33'sh0_8000_0000);

   logic hi_x, lo_x, hi_y, lo_y;

   assign hi_x = s8_x_ff > RES_MAX;
   assign lo_x = s8_x_ff < RES_MIN;
   assign hi_y = s8_y_ff > RES_MAX;
   assign lo_y = s8_y_ff < RES_MIN;

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         rsp_out_x    <= hi_x ? 32'sh7FFF_FFFF : lo_x ? 32'sh8000_0000
                                               : s8_x_ff[COORD_W-1:0];
         rsp_out_y    <= hi_y ? 32'sh7FFF_FFFF : lo_y ? 32'sh8000_0000
                                               : s8_y_ff[COORD_W-1:0];
         rsp_overflow <= hi_x | lo_x | hi_y | lo_y;
      end
   end

endmodule
